>>> rtl/hri_pkg.sv
// Package for the Halton radical inverse block: widths, controller states,
// and the command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package hri_pkg;

  localparam int INDEX_BITS    = 32;
  localparam int FRACTION_BITS = 32;
  localparam int BASE_BITS     = 8;

  // rev and scale stay below base * 2^INDEX_BITS
  localparam int ACC_BITS = INDEX_BITS + BASE_BITS;
  localparam int REM_BITS = ACC_BITS + 1;
  localparam int QUO_BITS = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
  localparam int CNT_BITS = $clog2(QUO_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIGIT,
    ST_UPDATE,
    ST_FRAC,
    ST_FINISH
  } hri_state_e;

  typedef struct packed {
    logic load;       // capture index/base, clear accumulators
    logic step;       // one restoring division step
    logic frac_mode;  // step divides rev by scale instead of index by base
    logic update;     // fold remainder digit into rev, scale by base
    logic frac_init;  // remainder <= rev, quotient <= 0
    logic out_load;   // write the output register
  } dp_cmd_t;

  typedef struct packed {
    logic bad_base;
    logic quo_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/halton_radical_inverse.sv
// Halton radical inverse: mirrors the base digits of an index into a Q0.32
// fraction, floor(R * 2^32 / base^n). Depends on hri_pkg, hri_ctrl, hri_datapath.
//
// One item at a time. Every digit costs one pass of the shared bit-serial
// divider (index / base), a fold of the digit and a test for the end; the
// final fraction takes one more pass through the same divider. A base below
// 2 returns with bad_base set and fraction 0. A new item is taken once the
// result is in the output register, even if that result has not yet been
// transferred.
`default_nettype none

module halton_radical_inverse (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [hri_pkg::INDEX_BITS-1:0]    index_i,
  input  wire logic [hri_pkg::BASE_BITS-1:0]     base_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [hri_pkg::FRACTION_BITS-1:0] fraction_o,
  output logic                                   bad_base_o
);

  hri_pkg::dp_cmd_t cmd;
  hri_pkg::dp_sts_t sts;

  hri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hri_datapath u_datapath (
    .clk_i      (clk_i),
    .index_i    (index_i),
    .base_i     (base_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .fraction_o (fraction_o),
    .bad_base_o (bad_base_o)
  );

endmodule

`default_nettype wire

>>> rtl/hri_datapath.sv
// Datapath: shared bit-serial restoring divider, digit accumulators, output register.
// Depends on hri_pkg.
`default_nettype none

module hri_datapath (
  input  wire logic                              clk_i,
  input  wire logic [hri_pkg::INDEX_BITS-1:0]    index_i,
  input  wire logic [hri_pkg::BASE_BITS-1:0]     base_i,
  input  wire hri_pkg::dp_cmd_t                  cmd_i,
  output hri_pkg::dp_sts_t                       sts_o,
  output logic      [hri_pkg::FRACTION_BITS-1:0] fraction_o,
  output logic                                   bad_base_o
);

  logic [hri_pkg::BASE_BITS-1:0]     base_q;
  logic [hri_pkg::QUO_BITS-1:0]      quo_q, quo_d;
  logic [hri_pkg::REM_BITS-1:0]      rem_q, rem_d;
  logic [hri_pkg::ACC_BITS-1:0]      rev_q, rev_d;
  logic [hri_pkg::ACC_BITS-1:0]      scale_q, scale_d;
  logic [hri_pkg::FRACTION_BITS-1:0] fraction_q;
  logic                              bad_base_q;

  logic                              shift_in;
  logic [hri_pkg::REM_BITS-1:0]      trial;
  logic [hri_pkg::REM_BITS-1:0]      divisor;
  logic                              ge;
  logic                              bad;

  assign bad = base_q < hri_pkg::BASE_BITS'(2);

  always_comb begin
    shift_in = cmd_i.frac_mode ? 1'b0 : quo_q[hri_pkg::INDEX_BITS-1];
    trial    = {rem_q[hri_pkg::ACC_BITS-1:0], shift_in};
    divisor  = cmd_i.frac_mode ? {1'b0, scale_q} : hri_pkg::REM_BITS'(base_q);
    ge       = trial >= divisor;

    quo_d   = quo_q;
    rem_d   = rem_q;
    rev_d   = rev_q;
    scale_d = scale_q;

    if (cmd_i.load) begin
      quo_d   = hri_pkg::QUO_BITS'(index_i);
      rem_d   = '0;
      rev_d   = '0;
      scale_d = hri_pkg::ACC_BITS'(1);
    end else if (cmd_i.step) begin
      quo_d = {quo_q[hri_pkg::QUO_BITS-2:0], ge};
      rem_d = ge ? (trial - divisor) : trial;
    end else if (cmd_i.update) begin
      rev_d   = hri_pkg::ACC_BITS'(rev_q * hri_pkg::ACC_BITS'(base_q))
              + rem_q[hri_pkg::ACC_BITS-1:0];
      scale_d = hri_pkg::ACC_BITS'(scale_q * hri_pkg::ACC_BITS'(base_q));
      rem_d   = '0;
    end else if (cmd_i.frac_init) begin
      quo_d = '0;
      rem_d = {1'b0, rev_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
    end
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    rev_q   <= rev_d;
    scale_q <= scale_d;
    if (cmd_i.out_load) begin
      fraction_q <= bad ? '0 : quo_q[hri_pkg::FRACTION_BITS-1:0];
      bad_base_q <= bad;
    end
  end

  assign sts_o.bad_base = bad;
  assign sts_o.quo_zero = quo_q[hri_pkg::INDEX_BITS-1:0] == '0;
  assign fraction_o     = fraction_q;
  assign bad_base_o     = bad_base_q;

endmodule

`default_nettype wire

>>> rtl/hri_ctrl.sv
// Controller: sequences digit divisions, digit folds, the fraction division
// and the output transfer. Depends on hri_pkg.
`default_nettype none

module hri_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire hri_pkg::dp_sts_t  sts_i,
  output hri_pkg::dp_cmd_t       cmd_o
);

  hri_pkg::hri_state_e          state_q, state_d;
  logic [hri_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hri_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;

    case (state_q)
      hri_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = hri_pkg::ST_CHECK;
        end
      end
      hri_pkg::ST_CHECK: begin
        if (sts_i.bad_base) begin
          state_d = hri_pkg::ST_FINISH;
        end else if (sts_i.quo_zero) begin
          cmd_o.frac_init = 1'b1;
          cnt_d           = hri_pkg::CNT_BITS'(hri_pkg::FRACTION_BITS - 1);
          state_d         = hri_pkg::ST_FRAC;
        end else begin
          cnt_d   = hri_pkg::CNT_BITS'(hri_pkg::INDEX_BITS - 1);
          state_d = hri_pkg::ST_DIGIT;
        end
      end
      hri_pkg::ST_DIGIT: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = hri_pkg::ST_UPDATE;
        end
      end
      hri_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = hri_pkg::ST_CHECK;
      end
      hri_pkg::ST_FRAC: begin
        cmd_o.step      = 1'b1;
        cmd_o.frac_mode = 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = hri_pkg::ST_FINISH;
        end
      end
      hri_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = hri_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hri_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // output register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == hri_pkg::ST_CHECK))
    else $error("accepted item did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hri_pkg::ST_FRAC && cnt_q == '0) |=> (state_q == hri_pkg::ST_FINISH))
    else $error("fraction division did not end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hri_pkg::ST_UPDATE) |-> $past(state_q == hri_pkg::ST_DIGIT))
    else $error("digit fold without division");

endmodule

`default_nettype wire
